// ===== rtl/core/pstu_pkg.sv =====
// ----------------------------------------------------------------------------
// pstu_pkg - shared types and helpers for the PPU scroll and dot timing unit
// Holds the raster constants, the loopy-address bit masks, the position
// struct passed between the timing counter and the address logic, and the
// coarse X / fine-coarse Y increment functions.
// ----------------------------------------------------------------------------
package pstu_pkg;

   // Raster geometry
   localparam logic [8:0] LAST_DOT      = 9'd340;
   localparam logic [8:0] SKIP_DOT      = 9'd339;
   localparam logic [8:0] PRE_LINE      = 9'd261;
   localparam logic [8:0] VBL_LINE      = 9'd241;
   localparam logic [8:0] VISIBLE_LINES = 9'd240;

   // Background fetch dots
   localparam logic [8:0] FIRST_X_DOT   = 9'd8;
   localparam logic [8:0] Y_STEP_DOT    = 9'd256;
   localparam logic [8:0] H_RELOAD_DOT  = 9'd257;
   localparam logic [8:0] PREFETCH_DOT0 = 9'd328;
   localparam logic [8:0] PREFETCH_DOT1 = 9'd336;
   localparam logic [8:0] V_RELOAD_FIRST = 9'd285;
   localparam logic [8:0] V_RELOAD_LAST  = 9'd304;
   localparam logic [8:0] FLAG_DOT      = 9'd1;

   // Fields of the 15-bit VRAM address v
   localparam logic [14:0] COARSE_X_MASK = 15'h001F;
   localparam logic [14:0] NT_H_BIT      = 15'h0400;
   localparam logic [14:0] FINE_Y_MASK   = 15'h7000;
   localparam logic [14:0] FINE_Y_ONE    = 15'h1000;
   localparam logic [14:0] COARSE_Y_MASK = 15'h03E0;
   localparam logic [14:0] NT_V_BIT      = 15'h0800;
   localparam logic [14:0] HORIZ_BITS    = 15'h041F;
   localparam logic [4:0]  COARSE_Y_WRAP = 5'd29;
   localparam logic [4:0]  COARSE_Y_MAX  = 5'd31;

   // Vertical reload walks bits 5..14, bit 10 is skipped on write
   localparam logic [3:0]  V_RELOAD_BASE = 4'd5;
   localparam logic [3:0]  V_RELOAD_SKIP = 4'd10;

   // Payload widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // Position of the tick being handled
   typedef struct packed {
      logic [8:0] line;
      logic [8:0] dot;
      logic       render_line;   // lines 0..239 or pre-render line
      logic       pre_line;      // pre-render line
   } pstu_pos_type;

   // Coarse X increment with horizontal nametable toggle
   function automatic logic [14:0] step_x(input logic [14:0] v);
      logic [14:0] r;
      if ((v & COARSE_X_MASK) == COARSE_X_MASK) begin
         r = (v & ~COARSE_X_MASK) ^ NT_H_BIT;
      end else begin
         r = v + 15'd1;
      end
      return r;
   endfunction

   // Fine Y / coarse Y increment
   function automatic logic [14:0] step_y(input logic [14:0] v);
      logic [14:0] r;
      logic [4:0]  cy;
      r  = v;
      cy = v[9:5];
      if ((v & FINE_Y_MASK) != FINE_Y_MASK) begin
         r = v + FINE_Y_ONE;
      end else begin
         r = v & ~FINE_Y_MASK;
         if (cy == COARSE_Y_WRAP) begin
            cy = 5'd0;
            r  = r ^ NT_V_BIT;
         end else if (cy == COARSE_Y_MAX) begin
            cy = 5'd0;
         end else begin
            cy = cy + 5'd1;
         end
         r = (r & ~COARSE_Y_MASK) | {5'd0, cy, 5'd0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/pstu_timing.sv =====
// ----------------------------------------------------------------------------
// pstu_timing - dot and scanline counters with vblank and frame parity
// Keeps the position of the next tick, the odd-frame bit and the vblank
// status bit, and flags the NMI pulse and visible-pixel area of a tick.
// ----------------------------------------------------------------------------
module pstu_timing (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  render_on,
   input  logic                  nmi_enable,
   output pstu_pkg::pstu_pos_type pos,
   output logic                  vblank_next,
   output logic                  nmi_pulse,
   output logic                  pixel_visible
);
   import pstu_pkg::*;

   logic [8:0] dot_ff, dot_in;
   logic [8:0] line_ff, line_in;
   logic       odd_ff, odd_in;
   logic       vblank_ff;
   logic       end_line;
   logic       vbl_start;
   logic       vbl_end;

   // Current position
   always_comb begin
      pos.line        = line_ff;
      pos.dot         = dot_ff;
      pos.render_line = (line_ff < VISIBLE_LINES) || (line_ff == PRE_LINE);
      pos.pre_line    = (line_ff == PRE_LINE);
   end

   // Vblank and NMI flags
   assign vbl_start     = (line_ff == VBL_LINE) && (dot_ff == FLAG_DOT);
   assign vbl_end       = (line_ff == PRE_LINE) && (dot_ff == FLAG_DOT);
   assign nmi_pulse     = vbl_start && nmi_enable;
   assign pixel_visible = (line_ff < VISIBLE_LINES) && (dot_ff >= 9'd1)
                          && (dot_ff <= Y_STEP_DOT);

   always_comb begin
      priority if (vbl_end) begin
         vblank_next = 1'b0;
      end else if (vbl_start) begin
         vblank_next = 1'b1;
      end else begin
         vblank_next = vblank_ff;
      end
   end

   // Next position, with the odd-frame dot skip
   always_comb begin
      end_line = (dot_ff >= LAST_DOT)
                 || ((line_ff == PRE_LINE) && (dot_ff == SKIP_DOT) && render_on && odd_ff);
      dot_in  = dot_ff + 9'd1;
      line_in = line_ff;
      odd_in  = odd_ff;
      if (end_line) begin
         dot_in = 9'd0;
         if (line_ff >= PRE_LINE) begin
            line_in = 9'd0;
            if (line_ff == PRE_LINE) begin
               odd_in = ~odd_ff;
            end
         end else begin
            line_in = line_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff    <= 9'd0;
         line_ff   <= 9'd0;
         odd_ff    <= 1'b0;
         vblank_ff <= 1'b0;
      end else if (step) begin
         dot_ff    <= dot_in;
         line_ff   <= line_in;
         odd_ff    <= odd_in;
         vblank_ff <= vblank_next;
      end
   end

endmodule

// ===== rtl/core/pstu_vaddr.sv =====
// ----------------------------------------------------------------------------
// pstu_vaddr - loopy VRAM address register and its per-dot update
// Holds v and the vertical reload latch; computes v after the current tick
// from the coarse X / Y increments and the horizontal and vertical reloads.
// ----------------------------------------------------------------------------
module pstu_vaddr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pstu_pkg::pstu_pos_type pos,
   input  logic                  render_on,
   input  logic [14:0]           temp_address,
   output logic [14:0]           vram_next
);
   import pstu_pkg::*;

   logic [14:0] scroll_ff;
   logic [14:0] latch_ff, latch_in;
   logic        x_dot;
   logic        v_window;
   logic [8:0]  v_offset;
   logic [3:0]  v_bit;
   logic [14:0] v_mask;
   logic [14:0] v_step;

   // Coarse X dots: every 8th from 8 to 256, plus the two prefetch tiles
   assign x_dot = ((pos.dot >= FIRST_X_DOT) && (pos.dot <= Y_STEP_DOT)
                   && (pos.dot[2:0] == 3'd0))
                  || (pos.dot == PREFETCH_DOT0) || (pos.dot == PREFETCH_DOT1);

   // Vertical reload: one bit per dot pair on the pre-render line
   assign v_window = pos.pre_line && (pos.dot >= V_RELOAD_FIRST)
                     && (pos.dot <= V_RELOAD_LAST);
   assign v_offset = pos.dot - V_RELOAD_FIRST;
   assign v_bit    = V_RELOAD_BASE + v_offset[4:1];
   assign v_mask   = 15'd1 << v_bit;

   always_comb begin
      v_step   = scroll_ff;
      latch_in = latch_ff;
      if (pos.render_line && render_on) begin
         if (x_dot) begin
            v_step = step_x(v_step);
            if (pos.dot == Y_STEP_DOT) begin
               v_step = step_y(v_step);
            end
         end
         if (pos.dot == H_RELOAD_DOT) begin
            v_step = (v_step & ~HORIZ_BITS) | (temp_address & HORIZ_BITS);
         end
      end
      if (v_window) begin
         if (pos.dot[0]) begin
            latch_in = temp_address & v_mask;
         end else if ((v_bit != V_RELOAD_SKIP) && render_on) begin
            v_step = (v_step & ~v_mask) | (latch_ff & v_mask);
         end
      end
   end

   assign vram_next = v_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff <= 15'd0;
         latch_ff  <= 15'd0;
      end else if (step) begin
         scroll_ff <= vram_next;
         latch_ff  <= latch_in;
      end
   end

endmodule

// ===== rtl/core/ppu_scroll_timing_unit.sv =====
// ----------------------------------------------------------------------------
// Each accepted transfer is one PPU dot tick and yields exactly one result:
// the tick's scanline and dot, the VRAM address v after the tick, the raw
// nametable and attribute fetch offsets, the vblank bit, the NMI pulse and
// the visible-pixel flag. One tick is accepted every clock cycle while the
// result side is not stalled. A tick goes to the input register, and its
// result is loaded into the result register when the tick leaves the input
// register; rsp_tvalid is driven from the result register. The state
// (position, v, frame parity, vblank) advances when a tick leaves the input
// register, so stalls on the result side only hold the pipeline. All state
// resets to line 0, dot 0, v = 0, even frame.
// ----------------------------------------------------------------------------
// ppu_scroll_timing_unit - PPU loopy scroll and dot timing
// Top level: stream handshake, input and result registers, and the
// timing and VRAM address units.
// ----------------------------------------------------------------------------
module ppu_scroll_timing_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] render_on, [1] nmi_enable, [16:2] temp_address
   input  logic [pstu_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [8:0] line_number, [17:9] dot_number, [32:18] vram_address,
   // [44:33] tile_fetch_offset, [56:45] attr_fetch_offset,
   // [57] vblank_flag, [58] nmi_pulse, [59] pixel_visible
   output logic [pstu_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import pstu_pkg::*;

   logic              in_valid_ff;
   logic              in_render_ff;
   logic              in_nmi_ff;
   logic [14:0]       in_temp_ff;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              advance;
   pstu_pos_type      pos;
   logic              vblank_next;
   logic              nmi_pulse;
   logic              pixel_visible;
   logic [14:0]       vram_next;
   logic [11:0]       attr_offset;

   // Pipeline handshake
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_render_ff <= req_tdata[0];
         in_nmi_ff    <= req_tdata[1];
         in_temp_ff   <= req_tdata[16:2];
      end
   end

   pstu_timing u_timing (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .render_on     (in_render_ff),
      .nmi_enable    (in_nmi_ff),
      .pos           (pos),
      .vblank_next   (vblank_next),
      .nmi_pulse     (nmi_pulse),
      .pixel_visible (pixel_visible)
   );

   pstu_vaddr u_vaddr (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .pos          (pos),
      .render_on    (in_render_ff),
      .temp_address (in_temp_ff),
      .vram_next    (vram_next)
   );

   // Attribute byte: 0x3C0 | nametable | coarse Y / 4 | coarse X / 4
   assign attr_offset = {vram_next[11:10], 4'b1111, vram_next[9:7], vram_next[4:2]};

   assign rsp_data_in = {4'd0, pixel_visible, nmi_pulse, vblank_next, attr_offset,
                         vram_next[11:0], vram_next, pos.dot, pos.line};

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
